[design/prd_table_builder_defines.svh]
// ----------------------------------------------------------------------------
// PRD table builder assertion macros
// Shorthand for clocked implication checks used in the table builder.
// ----------------------------------------------------------------------------
`ifndef PRD_TABLE_BUILDER_DEFINES_SVH
`define PRD_TABLE_BUILDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PRDTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PRDTB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/prdtb_pkg.sv]
// ----------------------------------------------------------------------------
// PRD table builder package
// Shared widths, constants, item kind codes and the piece result struct.
// ----------------------------------------------------------------------------
package prdtb_pkg;

    localparam int ADDR_W        = 32;
    localparam int SEG_LEN_W     = 18;
    localparam int CWORD_W       = 32;
    localparam int TOTAL_W       = 8;
    localparam int KIND_W        = 2;
    localparam int BCOUNT_W      = 17;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_SEG_BYTES     = 131072;

    localparam logic [BCOUNT_W-1:0] BOUNDARY = 17'h10000;
    localparam logic [15:0]         LOW_MASK = 16'hffff;
    localparam logic [CWORD_W-1:0]  END_BIT  = 32'h8000_0000;

    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT  = 2'd2;

    typedef struct packed {
        logic [CWORD_W-1:0]   count_word;
        logic [ADDR_W-1:0]    next_addr;
        logic [SEG_LEN_W-1:0] next_len;
        logic                 done;
    } t_piece;

endpackage

[design/prdtb_piece.sv]
// ----------------------------------------------------------------------------
// PRD table builder piece unit
// Cuts one piece off a segment at the next 64 KiB boundary or at the segment end,
// encodes its count word and gives the remaining address and length.
// ----------------------------------------------------------------------------
module prdtb_piece
    import prdtb_pkg::*;
(
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [SEG_LEN_W-1:0] i_len,
    input  logic                 i_dword_fmt,
    output t_piece               o_piece
);

    logic [BCOUNT_W-1:0] w_room;
    logic [BCOUNT_W-1:0] w_bcount;
    logic [15:0]         w_xcount;
    logic [15:0]         w_dwords;

    assign w_room   = BOUNDARY - {1'b0, i_addr[15:0] & LOW_MASK};
    assign w_bcount = ({1'b0, w_room} > i_len) ? i_len[BCOUNT_W-1:0] : w_room;
    assign w_xcount = w_bcount[15:0];
    assign w_dwords = {2'b00, w_xcount[15:2]} - 16'd1;

    always_comb begin
        o_piece.count_word = i_dword_fmt ? {w_dwords, 16'h0000} : {16'h0000, w_xcount};
        o_piece.next_addr  = i_addr + {{(ADDR_W-BCOUNT_W){1'b0}}, w_bcount};
        o_piece.next_len   = i_len - {{(SEG_LEN_W-BCOUNT_W){1'b0}}, w_bcount};
        o_piece.done       = (o_piece.next_len == '0);
    end

endmodule

[design/prd_table_builder.sv]
// ----------------------------------------------------------------------------
// PRD table builder
// Turns scatter-gather segments into physical region descriptor entries,
// splitting at 64 KiB boundaries and holding the newest entry back for the
// end bit.
//
//   channel  direction  handshake                 payload
//   segment  in         i_valid / o_stall         i_seg_addr, i_seg_len, i_last_segment
//   result   out        o_valid / i_stall         o_item_kind .. o_last_of_run
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_data
//
// A segment is accepted in idle and then cut into 64 KiB pieces through
// the shared piece unit; the end of a request adds the held entry, then the status.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the sequencer; the segment side is stalled until
// the sequencer is back in idle.
// ----------------------------------------------------------------------------
`include "prd_table_builder_defines.svh"

module prd_table_builder
    import prdtb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADDR_W-1:0]    i_seg_addr,
    input  logic [SEG_LEN_W-1:0] i_seg_len,
    input  logic                 i_last_segment,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [KIND_W-1:0]    o_item_kind,
    output logic [ADDR_W-1:0]    o_prd_addr,
    output logic [CWORD_W-1:0]   o_prd_count_word,
    output logic [TOTAL_W-1:0]   o_entry_total,
    output logic                 o_last_of_run,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [31:0]      SEG_MAX   = 32'(MAX_SEG_BYTES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SPLIT  = 4'b0010,
        S_FINAL  = 4'b0100,
        S_STATUS = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_fmt;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [SEG_LEN_W-1:0]  r_len, n_len;
    logic                  r_end, n_end;
    logic                  r_held_valid, n_held_valid;
    logic [ADDR_W-1:0]     r_held_addr, n_held_addr;
    logic [CWORD_W-1:0]    r_held_count, n_held_count;
    logic [CNT_W-1:0]      r_entries, n_entries;
    logic                  r_aborted, n_aborted;

    logic                  r_o_valid;
    logic [KIND_W-1:0]     r_o_kind;
    logic [ADDR_W-1:0]     r_o_addr;
    logic [CWORD_W-1:0]    r_o_cw;
    logic [TOTAL_W-1:0]    r_o_total;
    logic                  r_o_last;

    logic                  w_out_free;
    logic                  w_in_end;
    logic [SEG_LEN_W-1:0]  w_len_sat;
    logic [CNT_W+7:0]      w_ent_ext;
    t_piece                w_piece;

    logic                  e_emit;
    logic [KIND_W-1:0]     e_kind;
    logic [ADDR_W-1:0]     e_addr;
    logic [CWORD_W-1:0]    e_cw;
    logic                  e_last;

    prdtb_piece u_piece (
        .i_addr      (r_addr),
        .i_len       (r_len),
        .i_dword_fmt (r_fmt),
        .o_piece     (w_piece)
    );

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_len_sat  = ({14'd0, i_seg_len} > SEG_MAX) ? SEG_LEN_W'(MAX_SEG_BYTES) : i_seg_len;
    assign w_in_end   = i_last_segment || (w_len_sat == '0);
    assign w_ent_ext  = {8'd0, r_entries};

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_len        = r_len;
        n_end        = r_end;
        n_held_valid = r_held_valid;
        n_held_addr  = r_held_addr;
        n_held_count = r_held_count;
        n_entries    = r_entries;
        n_aborted    = r_aborted;
        e_emit       = 1'b0;
        e_kind       = KIND_ENTRY;
        e_addr       = r_held_addr;
        e_cw         = r_held_count;
        e_last       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_aborted) begin
                        n_aborted = !w_in_end;
                    end else begin
                        n_addr  = i_seg_addr;
                        n_len   = w_len_sat;
                        n_end   = w_in_end;
                        n_state = (w_len_sat == '0) ? S_FINAL : S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (w_out_free) begin
                    if (r_entries == LAST_SLOT) begin
                        e_emit       = 1'b1;
                        e_kind       = KIND_ABORT;
                        e_addr       = '0;
                        e_cw         = '0;
                        e_last       = 1'b1;
                        n_held_valid = 1'b0;
                        n_entries    = '0;
                        n_aborted    = !r_end;
                        n_state      = S_IDLE;
                    end else begin
                        e_emit       = r_held_valid;
                        e_last       = w_piece.done && !r_end;
                        n_entries    = r_entries + 1'b1;
                        n_held_valid = 1'b1;
                        n_held_addr  = r_addr;
                        n_held_count = w_piece.count_word;
                        n_addr       = w_piece.next_addr;
                        n_len        = w_piece.next_len;
                        if (w_piece.done) begin
                            n_state = r_end ? S_FINAL : S_IDLE;
                        end
                    end
                end
            end
            S_FINAL: begin
                if (w_out_free) begin
                    e_emit  = r_held_valid;
                    e_cw    = r_fmt ? r_held_count : (r_held_count | END_BIT);
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (w_out_free) begin
                    e_emit       = 1'b1;
                    e_kind       = KIND_STATUS;
                    e_addr       = '0;
                    e_cw         = '0;
                    e_last       = 1'b1;
                    n_held_valid = 1'b0;
                    n_entries    = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fmt        <= 1'b0;
            r_held_valid <= 1'b0;
            r_entries    <= '0;
            r_aborted    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_entries    <= n_entries;
            r_aborted    <= n_aborted;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            if (w_out_free) begin
                r_o_valid <= e_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_end        <= n_end;
        r_held_addr  <= n_held_addr;
        r_held_count <= n_held_count;
        if (w_out_free && e_emit) begin
            r_o_kind  <= e_kind;
            r_o_addr  <= e_addr;
            r_o_cw    <= e_cw;
            r_o_total <= w_ent_ext[7:0];
            r_o_last  <= e_last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_item_kind      = r_o_kind;
    assign o_prd_addr       = r_o_addr;
    assign o_prd_count_word = r_o_cw;
    assign o_entry_total    = r_o_total;
    assign o_last_of_run    = r_o_last;

    `PRDTB_ASSERT_IMP(a_run_open, r_o_valid && !r_o_last, r_state != S_IDLE, "result run left idle early")
    `PRDTB_ASSERT_IMP(a_abort_last, r_o_valid && (r_o_kind == KIND_ABORT), r_o_last, "abort item not last of run")
    `PRDTB_ASSERT_IMP(a_status_form, r_o_valid && (r_o_kind == KIND_STATUS), (r_o_addr == '0) && (r_o_cw == '0) && r_o_last, "malformed status item")
    `PRDTB_ASSERT_IMP(a_abort_clear, r_aborted, !r_held_valid && (r_entries == '0), "aborted request kept table state")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// PRD table builder testbench
// Feeds scatter-gather segments through a queued driver and checks every
// descriptor, status and abort item against a cycle-free predictor of the
// table state. It covers both count word formats, splitting at 64 KiB,
// address wrap, saturation, early ends, table overflow with dropped
// segments, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import prdtb_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0]    addr;
        logic [SEG_LEN_W-1:0] len;
        logic                 last;
        bit                   drain_first;
    } t_seg_req;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [CWORD_W-1:0] cword;
        logic [TOTAL_W-1:0] total;
        logic               last_run;
    } t_prd_item;

    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 seg_valid = 1'b0;
    logic [ADDR_W-1:0]    seg_addr = '0;
    logic [SEG_LEN_W-1:0] seg_len = '0;
    logic                 seg_last = 1'b0;
    logic                 o_stall;

    logic                 o_valid;
    logic                 res_stall = 1'b1;
    logic [KIND_W-1:0]    o_item_kind;
    logic [ADDR_W-1:0]    o_prd_addr;
    logic [CWORD_W-1:0]   o_prd_count_word;
    logic [TOTAL_W-1:0]   o_entry_total;
    logic                 o_last_of_run;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_data = 1'b0;
    logic                 o_cfg_ready;

    t_seg_req  pending_segs[$];
    t_prd_item prd_expect[$];

    int n_sent = 0;
    int n_expected = 0;
    int n_checked = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    int send_gap = 0;
    int recv_wait = 0;
    int errors = 0;
    int n_entries = 0;
    int n_status = 0;
    int n_abort = 0;
    int n_phases = 0;
    int phase_items = 0;

    // predictor state
    bit                 fmt_dword = 1'b0;
    bit                 held_pend = 1'b0;
    logic [ADDR_W-1:0]  held_addr = '0;
    logic [CWORD_W-1:0] held_cword = '0;
    int unsigned        made_count = 0;
    bit                 dropping = 1'b0;

    prd_table_builder u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_valid          (seg_valid),
        .o_stall          (o_stall),
        .i_seg_addr       (seg_addr),
        .i_seg_len        (seg_len),
        .i_last_segment   (seg_last),
        .o_valid          (o_valid),
        .i_stall          (res_stall),
        .o_item_kind      (o_item_kind),
        .o_prd_addr       (o_prd_addr),
        .o_prd_count_word (o_prd_count_word),
        .o_entry_total    (o_entry_total),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic void clear_table();
        held_pend = 1'b0;
        held_addr = '0;
        held_cword = '0;
        made_count = 0;
    endfunction

    function automatic t_prd_item make_item(input logic [KIND_W-1:0] kind,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [CWORD_W-1:0] cword,
                                            input int unsigned total);
        t_prd_item it;
        it.kind = kind;
        it.addr = addr;
        it.cword = cword;
        it.total = total[TOTAL_W-1:0];
        it.last_run = 1'b0;
        return it;
    endfunction

    function automatic int predict_table(input logic [ADDR_W-1:0] a_in,
                                         input logic [SEG_LEN_W-1:0] l_in,
                                         input logic last_in);
        t_prd_item          run[$];
        logic [ADDR_W-1:0]  addr;
        logic [CWORD_W-1:0] cw;
        int unsigned        len;
        int unsigned        piece;
        bit                 fin;
        addr = a_in;
        len = l_in;
        if (len > MAX_SEG_BYTES) len = MAX_SEG_BYTES;
        fin = last_in || len == 0;
        if (dropping) begin
            if (fin) begin
                dropping = 1'b0;
                clear_table();
            end
            return 0;
        end
        while (len != 0) begin
            if (made_count + 1 >= TABLE_ENTRIES_DEF) begin
                run.push_back(make_item(KIND_ABORT, '0, '0, made_count));
                clear_table();
                dropping = !fin;
                len = 0;
                fin = 1'b0;
            end else begin
                if (held_pend)
                    run.push_back(make_item(KIND_ENTRY, held_addr, held_cword, made_count));
                made_count++;
                piece = int'(BOUNDARY) - int'(addr[15:0]);
                if (piece > len) piece = len;
                cw = {16'h0, piece[15:0]};
                if (fmt_dword) cw = ((cw >> 2) - 32'd1) << 16;
                held_pend = 1'b1;
                held_addr = addr;
                held_cword = cw;
                addr = addr + piece;
                len = len - piece;
            end
        end
        if (fin) begin
            if (held_pend)
                run.push_back(make_item(KIND_ENTRY, held_addr,
                                        fmt_dword ? held_cword : (held_cword | END_BIT),
                                        made_count));
            run.push_back(make_item(KIND_STATUS, '0, '0, made_count));
            clear_table();
        end
        if (run.size() != 0) run[run.size()-1].last_run = 1'b1;
        foreach (run[i]) prd_expect.push_back(run[i]);
        return run.size();
    endfunction

    // segment driver
    always @(posedge i_clk) begin : drive_seg
        int made;
        if (!rst_n) begin
            seg_valid <= 1'b0;
        end else if (!(seg_valid && o_stall)) begin
            if (seg_valid) begin
                made = predict_table(seg_addr, seg_len, seg_last);
                n_expected <= n_expected + made;
                n_sent <= n_sent + 1;
                send_gap = n_sent[6] ? 0 : $urandom_range(0, 4);
            end
            if (send_gap > 0) begin
                send_gap--;
                seg_valid <= 1'b0;
            end else if (pending_segs.size() != 0 && (!pending_segs[0].drain_first ||
                         (!seg_valid && n_expected == n_checked))) begin
                seg_valid <= 1'b1;
                seg_addr <= pending_segs[0].addr;
                seg_len <= pending_segs[0].len;
                seg_last <= pending_segs[0].last;
                void'(pending_segs.pop_front());
            end else begin
                seg_valid <= 1'b0;
            end
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_sent == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_results
        t_prd_item want;
        if (!rst_n) begin
            res_stall <= 1'b1;
            recv_wait = 0;
        end else begin
            if (o_valid && !res_stall) begin
                if (prd_expect.size() == 0) begin
                    flag_error($sformatf("unexpected item kind %0d addr %h",
                                         o_item_kind, o_prd_addr));
                end else begin
                    want = prd_expect.pop_front();
                    n_checked <= n_checked + 1;
                    if (o_item_kind !== want.kind)
                        flag_error($sformatf("item kind %0d, expected %0d",
                                             o_item_kind, want.kind));
                    if (o_prd_addr !== want.addr)
                        flag_error($sformatf("address %h, expected %h",
                                             o_prd_addr, want.addr));
                    if (o_prd_count_word !== want.cword)
                        flag_error($sformatf("count word %h, expected %h",
                                             o_prd_count_word, want.cword));
                    if (o_entry_total !== want.total)
                        flag_error($sformatf("entry total %0d, expected %0d",
                                             o_entry_total, want.total));
                    if (o_last_of_run !== want.last_run)
                        flag_error($sformatf("last of run %b, expected %b",
                                             o_last_of_run, want.last_run));
                    case (want.kind)
                        KIND_ENTRY:  n_entries++;
                        KIND_STATUS: n_status++;
                        default:     n_abort++;
                    endcase
                end
                recv_wait = n_checked[5] ? 0 : $urandom_range(0, 4);
            end
            if (hold_left != 0 || recv_wait != 0) begin
                if (recv_wait != 0) recv_wait--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    task automatic add_seg(input logic [ADDR_W-1:0] addr, input int unsigned len,
                           input logic last, input bit drain = 1'b0);
        t_seg_req s;
        s.addr = addr;
        s.len = len[SEG_LEN_W-1:0];
        s.last = last;
        s.drain_first = drain;
        pending_segs.push_back(s);
        phase_items++;
    endtask

    task automatic add_directed();
        add_seg(32'h0000_4000, 0, 1'b0);
        add_seg(32'h0000_8000, 0, 1'b1);
        add_seg(32'h0000_1000, 4, 1'b1);
        add_seg(32'h0000_fffe, 4, 1'b0);
        add_seg(32'hffff_fff0, 32, 1'b0);
        add_seg(32'h0000_0000, MAX_SEG_BYTES, 1'b0);
        add_seg(32'h1234_5678, 18'h3ffff, 1'b0);
        add_seg(32'h5555_aaaa, 0, 1'b0);
        add_seg(32'h0000_0100, 1, 1'b0);
        add_seg(32'h0000_0200, 2, 1'b0);
        add_seg(32'h0000_0300, 3, 1'b0);
        add_seg(32'h0002_0000, 65536, 1'b1);
        add_seg(32'hffff_ffff, 1, 1'b1);
        add_seg(32'h0000_8000, MAX_SEG_BYTES + 1, 1'b1);
    endtask

    task automatic add_request(input bit drain);
        logic [ADDR_W-1:0] addr;
        int unsigned len;
        int nseg;
        int sel;
        logic last;
        nseg = $urandom_range(1, 6);
        for (int i = 0; i < nseg; i++) begin
            addr = $urandom;
            sel = $urandom_range(0, 9);
            if (sel == 6) addr[15:0] = 16'hffff - 16'($urandom_range(0, 7));
            else if (sel == 7) addr[15:0] = 16'h0;
            else if (sel == 8) addr[31:8] = 24'hffffff;
            sel = $urandom_range(0, 15);
            if (sel < 6) len = $urandom_range(1, 64);
            else if (sel < 10) len = $urandom_range(1, 65536);
            else if (sel < 13) len = $urandom_range(65536, MAX_SEG_BYTES);
            else if (sel < 15) len = $urandom_range(0, 2**SEG_LEN_W - 1);
            else len = $urandom_range(0, 1) ? 65536 : MAX_SEG_BYTES;
            last = (i == nseg - 1);
            if (last && $urandom_range(0, 9) == 0) begin
                len = 0;
                last = 1'b0;
            end
            add_seg(addr, len, last, drain && i == 0);
        end
    endtask

    // every segment yields three entries, so the table fills on segment 86
    task automatic add_overflow(input bit end_on_abort);
        logic [ADDR_W-1:0] addr;
        int count;
        count = end_on_abort ? 86 : 90;
        for (int i = 0; i < count; i++) begin
            addr = $urandom;
            if (addr[15:0] == 16'h0) addr[0] = 1'b1;
            if (i < 86)
                add_seg(addr, $urandom_range(MAX_SEG_BYTES, 2**SEG_LEN_W - 1),
                        end_on_abort && i == count - 1);
            else if (i < count - 1)
                add_seg(addr, $urandom_range(1, 2**SEG_LEN_W - 1), 1'b0);
            else
                add_seg(addr, 0, 1'b0);
        end
    endtask

    task automatic set_format(input logic fmt);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        fmt_dword = fmt;
        n_phases++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_segs.size() != 0 || seg_valid || n_expected != n_checked);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        set_format(1'b0);
        add_directed();
        wait_idle();
        set_format(1'b1);
        add_directed();
        wait_idle();
        for (int p = 0; p < 4; p++) begin
            set_format(p[0]);
            phase_items = 0;
            if (p == 0) add_overflow(1'b0);
            if (p == 3) add_overflow(1'b1);
            while (phase_items < 112)
                add_request(p == 2 && phase_items == 0 || $urandom_range(0, 24) == 0);
            wait_idle();
        end
        if (prd_expect.size() != 0)
            flag_error($sformatf("%0d items never arrived", prd_expect.size()));
        $display("Sent %0d segments over %0d format settings; checked %0d entries,",
                 n_sent, n_phases, n_entries);
        $display("%0d table statuses and %0d overflow aborts", n_status, n_abort);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d items outstanding", prd_expect.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
